/* rtl/qaem_pkg.sv */
// qaem_pkg: shared types, mode codes and constants of the QUBO annealing move engine.
// Depends on nothing; files other than qaem_if and qaem_ram use its names by scope.
`default_nettype none
package qaem_pkg;

  localparam int GAIN_BITS = 24;
  localparam int OBJ_BITS  = 29;
  localparam int FRAC_BITS = 12;

  localparam logic [2:0] MODE_WRITE   = 3'd0;
  localparam logic [2:0] MODE_START   = 3'd1;
  localparam logic [2:0] MODE_INIT    = 3'd2;
  localparam logic [2:0] MODE_PROPOSE = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  // 2^-(2^-b) in Q0.32, b = 1 .. FRAC_BITS
  localparam logic [31:0] POW_HALF_Q32 [FRAC_BITS] = '{
    32'd3037000500, 32'd3611622603, 32'd3938502376, 32'd4112874753,
    32'd4202935003, 32'd4248722085, 32'd4271771996, 32'd4283353945,
    32'd4289156690, 32'd4292061010, 32'd4293513907, 32'd4294240540
  };

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_WR2, ST_INIT, ST_PGAIN, ST_PDEC, ST_FLIP, ST_DONE
  } state_t;

  typedef struct packed {
    logic acc;
    logic up;
  } dec_t;

  // 2^-q for a Q0.12 fraction q, rounded to Q0.16 (may reach 65536)
  function automatic logic [16:0] exp_q(input logic [FRAC_BITS-1:0] q);
    logic [63:0] m;
    logic [63:0] r;
    m = 64'h1_0000_0000;
    for (int b = 0; b < FRAC_BITS; b++) begin
      if (q[FRAC_BITS-1-b]) begin
        m = (m * 64'(POW_HALF_Q32[b])) >> 32;
      end
    end
    r = (m + 64'd32768) >> 16;
    return r[16:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/qaem_if.sv */
// qaem_if: valid/ready channels for items in and results out.
// Depends on nothing.
`default_nettype none
interface qaem_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [5:0]        first_index;
  logic [5:0]        second_index;
  logic signed [15:0] weight;
  logic              bit_req;
  logic [15:0]       uniform;
  logic [15:0]       inv_temp;
  modport source (output valid, mode, first_index, second_index, weight, bit_req,
                  uniform, inv_temp, input ready);
  modport sink   (input valid, mode, first_index, second_index, weight, bit_req,
                  uniform, inv_temp, output ready);
  modport mon    (input valid, ready, mode, first_index, second_index, weight,
                  bit_req, uniform, inv_temp);
endinterface

interface qaem_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               uphill;
  logic signed [28:0] current_value;
  logic signed [28:0] best_value;
  logic               best_bit;
  modport source (output valid, accepted, uphill, current_value, best_value, best_bit,
                  input ready);
  modport sink   (input valid, accepted, uphill, current_value, best_value, best_bit,
                  output ready);
  modport mon    (input valid, ready, accepted, uphill, current_value, best_value,
                  best_bit);
endinterface
`default_nettype wire

/* rtl/qaem_ram.sv */
// qaem_ram: single write port, single read port memory with registered read data.
// Depends on nothing; holds the weights and the flip gains.
`default_nettype none
module qaem_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/qaem_accept.sv */
// qaem_accept: acceptance test, uphill always passes; downhill: registered gain times
// inverse temperature, then a fraction table lookup and shift. Depends on qaem_pkg.
`default_nettype none
module qaem_accept #(
  parameter int ENTRIES = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic signed [qaem_pkg::GAIN_BITS-1:0]  gain,
  input  wire logic [15:0]                            uniform,
  input  wire logic [15:0]                            inv_temp,
  output qaem_pkg::dec_t                              dec
);
  localparam int GB  = qaem_pkg::GAIN_BITS;
  localparam int FB  = qaem_pkg::FRAC_BITS;
  localparam int EW  = GB + 16;
  localparam int IXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic signed [GB:0] g_ext;
  logic signed [GB:0] g_neg;
  logic [GB-1:0]      mag;
  logic [EW-1:0]      e_r;
  logic               up_r;
  logic [15:0]        uni_r;
  logic [EW-FB-1:0]   sh;
  logic               too_far;
  logic [FB+IXW:0]    idx_prod;
  logic [IXW-1:0]     idx;
  logic [16:0]        tab [ENTRIES];
  logic [16:0]        thr;

  for (genvar t = 0; t < ENTRIES; t++) begin : g_tab
    localparam int Q = (t * (2 ** FB)) / ENTRIES;
    assign tab[t] = qaem_pkg::exp_q(FB'(Q));
  end

  assign g_ext = (GB+1)'(gain);
  assign g_neg = -g_ext;
  assign mag   = g_neg[GB-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      e_r   <= EW'(mag) * EW'(inv_temp);
      up_r  <= (gain > 0);
      uni_r <= uniform;
    end
  end

  assign sh       = e_r[EW-1:FB];
  assign too_far  = (|sh[EW-FB-1:5]) || (sh[4:0] >= 5'd17);
  assign idx_prod = (FB+IXW+1)'(e_r[FB-1:0]) * (FB+IXW+1)'(ENTRIES);
  assign idx      = idx_prod[FB+IXW-1:FB];
  assign thr      = tab[idx] >> sh[4:0];

  assign dec.up  = up_r;
  assign dec.acc = up_r || (!too_far && ({1'b0, uni_r} < thr));
endmodule
`default_nettype wire

/* rtl/qubo_annealing_move_engine_top.sv */
// qubo_annealing_move_engine_top: single-flip annealing engine over a weight memory
// and a gain memory. Depends on qaem_pkg, qaem_if, qaem_ram and qaem_accept.
//
// Items arrive on in_ch (valid/ready); each gives exactly one result on out_ch.
// Mode 0 writes a symmetric weight pair, mode 1 sets a start bit and mode 4 reads a
// best bit, mode 2 computes every gain and the objective by walking the whole weight
// memory, one weight a cycle. Mode 3 reads the gain, runs the acceptance test, and
// an accepted flip walks one weight row, updating one gain a cycle through the
// single weight read port.
// One item is worked on at a time; in_ch.ready is high only while idle. The
// result sits in an output register, so a stalled receiver holds the result and
// the engine goes on to accept the next item, waiting only to hand over the one
// after that.
// After reset the weight memory is cleared, one entry a cycle, and no item is
// accepted until every entry is cleared. Gains hold nothing usable until a
// mode 2 item has run.
`default_nettype none
module qubo_annealing_move_engine_top #(
  parameter int VARS              = 64,
  parameter int WEIGHT_BITS       = 16,
  parameter int EXP_TABLE_ENTRIES = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  qaem_in_if.sink   in_ch,
  qaem_out_if.source out_ch
);
  localparam int GB = qaem_pkg::GAIN_BITS;
  localparam int OB = qaem_pkg::OBJ_BITS;
  localparam int IW = $clog2(VARS);
  localparam int CW = $clog2(VARS + 1);
  localparam int WD = VARS * VARS;
  localparam int AW = $clog2(WD);

  qaem_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]          i_r, i_nxt, j_r, j_nxt;
  logic                   p_vld_r, p_vld_nxt;
  logic [IW-1:0]          p_i_r, p_i_nxt, p_j_r, p_j_nxt;
  logic [IW-1:0]          k_r, k_nxt, b_r, b_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [15:0]            uni_r, uni_nxt, inv_r, inv_nxt;
  logic [VARS-1:0]        bits_r, bits_nxt, best_bits_r, best_bits_nxt;
  logic signed [OB-1:0]   cur_obj_r, cur_obj_nxt, best_obj_r, best_obj_nxt;
  logic signed [OB-1:0]   obj_acc_r, obj_acc_nxt;
  logic signed [GB-1:0]   g_acc_r, g_acc_nxt, gk_r, gk_nxt;
  logic                   res_acc_r, res_acc_nxt, res_up_r, res_up_nxt;
  logic                   res_bb_r, res_bb_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic                   o_acc_r, o_acc_nxt, o_up_r, o_up_nxt, o_bb_r, o_bb_nxt;
  logic signed [OB-1:0]   o_cur_r, o_cur_nxt, o_best_r, o_best_nxt;

  logic                   in_acc, out_free;
  logic [IW-1:0]          a_in, b_in;
  logic                   a_ok, b_ok;
  logic signed [31:0]     win32;

  logic                   w_we;
  logic [AW-1:0]          w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
  logic                   g_we;
  logic [IW-1:0]          g_waddr, g_raddr;
  logic [GB-1:0]          g_wdata, g_rdata;

  logic signed [31:0]     wq32;
  logic signed [GB-1:0]   w24, term, g_new;
  logic signed [OB-1:0]   w29, obj_new;
  logic                   xi, xj;
  qaem_pkg::dec_t         dec;

  function automatic logic [AW-1:0] waddr_f(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(VARS) + AW'(c);
  endfunction

  qaem_ram #(.DEPTH(WD), .WIDTH(WEIGHT_BITS)) u_wmem (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  qaem_ram #(.DEPTH(VARS), .WIDTH(GB)) u_gmem (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  qaem_accept #(.ENTRIES(EXP_TABLE_ENTRIES)) u_accept (
    .clk(clk), .en(state_r == qaem_pkg::ST_PGAIN), .gain(g_rdata),
    .uniform(uni_r), .inv_temp(inv_r), .dec(dec)
  );

  assign in_ch.ready = (state_r == qaem_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_r || out_ch.ready;
  assign a_in        = IW'(in_ch.first_index);
  assign b_in        = IW'(in_ch.second_index);
  assign a_ok        = (32'(in_ch.first_index) < VARS);
  assign b_ok        = (32'(in_ch.second_index) < VARS);
  assign win32       = 32'(in_ch.weight);

  assign wq32 = 32'(signed'(w_rdata));
  assign w24  = wq32[GB-1:0];
  assign w29  = wq32[OB-1:0];
  assign xi   = bits_r[p_i_r];
  assign xj   = bits_r[p_j_r];

  assign out_ch.valid         = out_vld_r;
  assign out_ch.accepted      = o_acc_r;
  assign out_ch.uphill        = o_up_r;
  assign out_ch.current_value = o_cur_r;
  assign out_ch.best_value    = o_best_r;
  assign out_ch.best_bit      = o_bb_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qaem_pkg::ST_CLR: begin
        if (i_r == CW'(VARS - 1) && j_r == CW'(VARS - 1)) state_nxt = qaem_pkg::ST_IDLE;
      end
      qaem_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.mode)
            qaem_pkg::MODE_WRITE:   state_nxt = (a_ok && b_ok) ? qaem_pkg::ST_WR2
                                                               : qaem_pkg::ST_DONE;
            qaem_pkg::MODE_INIT:    state_nxt = qaem_pkg::ST_INIT;
            qaem_pkg::MODE_PROPOSE: state_nxt = a_ok ? qaem_pkg::ST_PGAIN
                                                     : qaem_pkg::ST_DONE;
            default:                state_nxt = qaem_pkg::ST_DONE;
          endcase
        end
      end
      qaem_pkg::ST_WR2:   state_nxt = qaem_pkg::ST_DONE;
      qaem_pkg::ST_PGAIN: state_nxt = qaem_pkg::ST_PDEC;
      qaem_pkg::ST_PDEC:  state_nxt = dec.acc ? qaem_pkg::ST_FLIP : qaem_pkg::ST_DONE;
      qaem_pkg::ST_INIT, qaem_pkg::ST_FLIP: begin
        if (i_r == CW'(VARS) && !p_vld_r) state_nxt = qaem_pkg::ST_DONE;
      end
      qaem_pkg::ST_DONE: begin
        if (out_free) state_nxt = qaem_pkg::ST_IDLE;
      end
      default: state_nxt = qaem_pkg::ST_CLR;
    endcase
  end

  always_comb begin
    i_nxt = i_r;  j_nxt = j_r;
    p_vld_nxt = 1'b0;  p_i_nxt = p_i_r;  p_j_nxt = p_j_r;
    k_nxt = k_r;  b_nxt = b_r;  w_nxt = w_r;  uni_nxt = uni_r;  inv_nxt = inv_r;
    bits_nxt = bits_r;  best_bits_nxt = best_bits_r;
    cur_obj_nxt = cur_obj_r;  best_obj_nxt = best_obj_r;  obj_acc_nxt = obj_acc_r;
    g_acc_nxt = g_acc_r;  gk_nxt = gk_r;
    res_acc_nxt = res_acc_r;  res_up_nxt = res_up_r;  res_bb_nxt = res_bb_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    o_acc_nxt = o_acc_r;  o_up_nxt = o_up_r;  o_bb_nxt = o_bb_r;
    o_cur_nxt = o_cur_r;  o_best_nxt = o_best_r;
    w_we = 1'b0;  w_waddr = waddr_f(i_r[IW-1:0], j_r[IW-1:0]);  w_wdata = '0;
    w_raddr = waddr_f(i_r[IW-1:0], j_r[IW-1:0]);
    g_we = 1'b0;  g_waddr = p_i_r;  g_wdata = '0;
    g_raddr = i_r[IW-1:0];
    term = '0;  g_new = '0;  obj_new = '0;

    case (state_r)
      qaem_pkg::ST_CLR: begin
        w_we = 1'b1;
        if (j_r == CW'(VARS - 1)) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      qaem_pkg::ST_IDLE: begin
        g_raddr = a_in;
        if (in_acc) begin
          k_nxt = a_in;  b_nxt = b_in;  w_nxt = win32[WEIGHT_BITS-1:0];
          uni_nxt = in_ch.uniform;  inv_nxt = in_ch.inv_temp;
          res_acc_nxt = 1'b0;  res_up_nxt = 1'b0;  res_bb_nxt = 1'b0;
          i_nxt = '0;  j_nxt = '0;  obj_acc_nxt = '0;
          case (in_ch.mode)
            qaem_pkg::MODE_WRITE: begin
              w_we    = a_ok && b_ok;
              w_waddr = waddr_f(a_in, b_in);
              w_wdata = win32[WEIGHT_BITS-1:0];
            end
            qaem_pkg::MODE_START: begin
              if (a_ok) bits_nxt[a_in] = in_ch.bit_req;
            end
            qaem_pkg::MODE_READ: begin
              res_bb_nxt = a_ok && best_bits_r[a_in];
            end
            default: ;
          endcase
        end
      end
      qaem_pkg::ST_WR2: begin
        w_we    = 1'b1;
        w_waddr = waddr_f(b_r, k_r);
        w_wdata = w_r;
      end
      qaem_pkg::ST_INIT: begin
        w_raddr = waddr_f(i_r[IW-1:0], j_r[IW-1:0]);
        if (i_r != CW'(VARS)) begin
          p_vld_nxt = 1'b1;  p_i_nxt = i_r[IW-1:0];  p_j_nxt = j_r[IW-1:0];
          if (j_r == CW'(VARS - 1)) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
        if (p_vld_r) begin
          if (p_i_r == p_j_r) term = w24;
          else if (xj)         term = w24 <<< 1;
          g_new = ((p_j_r == '0) ? '0 : g_acc_r) + (xi ? -term : term);
          g_acc_nxt = g_new;
          if (xi && xj) obj_acc_nxt = obj_acc_r + w29;
          g_we    = (p_j_r == IW'(VARS - 1));
          g_wdata = g_new;
        end
        if (i_r == CW'(VARS) && !p_vld_r) begin
          cur_obj_nxt   = obj_acc_r;
          best_obj_nxt  = obj_acc_r;
          best_bits_nxt = bits_r;
        end
      end
      qaem_pkg::ST_PGAIN: begin
        gk_nxt = g_rdata;
      end
      qaem_pkg::ST_PDEC: begin
        res_acc_nxt = dec.acc;
        res_up_nxt  = dec.up;
        if (dec.acc) begin
          bits_nxt[k_r] = !bits_r[k_r];
          obj_new     = cur_obj_r + OB'(gk_r);
          cur_obj_nxt = obj_new;
          if (obj_new > best_obj_r) begin
            best_obj_nxt  = obj_new;
            best_bits_nxt = bits_nxt;
          end
        end
      end
      qaem_pkg::ST_FLIP: begin
        w_raddr = waddr_f(k_r, i_r[IW-1:0]);
        g_raddr = i_r[IW-1:0];
        if (i_r != CW'(VARS)) begin
          p_vld_nxt = 1'b1;
          p_i_nxt   = i_r[IW-1:0];
          i_nxt     = i_r + 1'b1;
        end
        if (p_vld_r) begin
          term = w24 <<< 1;
          // term sign: negative when variable i sits at the flipped bit's new value
          if (p_i_r == k_r) g_new = -signed'(g_rdata);
          else              g_new = signed'(g_rdata) + ((xi == bits_r[k_r]) ? -term : term);
          g_we    = 1'b1;
          g_wdata = g_new;
        end
      end
      qaem_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          o_acc_nxt = res_acc_r;  o_up_nxt = res_up_r;  o_bb_nxt = res_bb_r;
          o_cur_nxt = cur_obj_r;  o_best_nxt = best_obj_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qaem_pkg::ST_CLR;
      i_r         <= '0;
      j_r         <= '0;
      p_vld_r     <= 1'b0;
      bits_r      <= '0;
      best_bits_r <= '0;
      cur_obj_r   <= '0;
      best_obj_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      p_vld_r     <= p_vld_nxt;
      bits_r      <= bits_nxt;
      best_bits_r <= best_bits_nxt;
      cur_obj_r   <= cur_obj_nxt;
      best_obj_r  <= best_obj_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_i_r <= p_i_nxt;  p_j_r <= p_j_nxt;
    k_r <= k_nxt;  b_r <= b_nxt;  w_r <= w_nxt;  uni_r <= uni_nxt;  inv_r <= inv_nxt;
    obj_acc_r <= obj_acc_nxt;  g_acc_r <= g_acc_nxt;  gk_r <= gk_nxt;
    res_acc_r <= res_acc_nxt;  res_up_r <= res_up_nxt;  res_bb_r <= res_bb_nxt;
    o_acc_r <= o_acc_nxt;  o_up_r <= o_up_nxt;  o_bb_r <= o_bb_nxt;
    o_cur_r <= o_cur_nxt;  o_best_r <= o_best_nxt;
  end
endmodule
`default_nettype wire

/* rtl/qaem_chk.sv */
// qaem_chk: port-level checks of the annealing engine, bound to the top level.
// Depends on qaem_pkg.
`default_nettype none
module qaem_chk (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic                                  out_accepted,
  input wire logic                                  out_uphill,
  input wire logic signed [qaem_pkg::OBJ_BITS-1:0]  out_current_value,
  input wire logic signed [qaem_pkg::OBJ_BITS-1:0]  out_best_value
);
  // one item at a time: an accepted item drops ready on the next edge
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  a_best_ge_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_best_value >= out_current_value))
    else $error("best objective below current objective");

  a_up_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_uphill) |-> out_accepted)
    else $error("uphill flip not accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_current_value)))
    else $error("stalled result dropped or changed");
endmodule

bind qubo_annealing_move_engine_top qaem_chk u_qaem_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_accepted(out_ch.accepted), .out_uphill(out_ch.uphill),
  .out_current_value(out_ch.current_value), .out_best_value(out_ch.best_value)
);
`default_nettype wire

/* tb/qubo_annealing_move_engine_top_tb.sv */
// Testbench for qubo_annealing_move_engine_top: drives items on in_ch and checks every
// result on out_ch against an in-bench predictor of the annealing engine.
// Depends on qaem_pkg, qaem_if and qubo_annealing_move_engine_top.
module qubo_annealing_move_engine_top_tb;

  localparam int NV = 64;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         first_index;
    logic [5:0]         second_index;
    logic signed [15:0] weight;
    logic               bit_req;
    logic [15:0]        uniform;
    logic [15:0]        inv_temp;
  } step_t;

  typedef struct packed {
    logic               accepted;
    logic               uphill;
    logic signed [28:0] current_value;
    logic signed [28:0] best_value;
    logic               best_bit;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   errors = 0;
  bit   idle_on = 1'b1;

  qaem_in_if  in_ch();
  qaem_out_if out_ch();

  qubo_annealing_move_engine_top uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] w_mem [NV][NV];
  logic [NV-1:0]      x_cur, x_best;
  logic signed [23:0] gain [NV];
  logic signed [28:0] obj_cur, obj_best;
  outcome_t           expected_q [$];

  function automatic logic [16:0] exp_frac(input logic [11:0] frac);
    logic [63:0] m;
    logic [11:0] q;
    logic [11:0] idx;
    idx = 12'((32'(frac) * 64) >> 12);
    q = 12'((32'(idx) << 12) / 64);
    m = 64'h1_0000_0000;
    for (int b = 0; b < 12; b++)
      if (q[11-b]) m = (m * 64'(qaem_pkg::POW_HALF_Q32[b])) >> 32;
    m = (m + 64'd32768) >> 16;
    return m[16:0];
  endfunction

  function automatic bit downhill_ok(input logic signed [23:0] g, input logic [15:0] u,
                                     input logic [15:0] it);
    logic [63:0] e;
    logic [63:0] sh;
    e = 64'(-64'(g)) * 64'(it);
    sh = e >> 12;
    if (sh >= 17) return 1'b0;
    return 64'(u) < (64'(exp_frac(e[11:0])) >> sh);
  endfunction

  task automatic recompute_gains();
    longint o, g, s;
    o = 0;
    for (int i = 0; i < NV; i++) begin
      s = x_cur[i] ? -1 : 1;
      g = longint'(w_mem[i][i]) * s;
      for (int j = 0; j < NV; j++) begin
        if (x_cur[i] && x_cur[j]) o += w_mem[i][j];
        if (j != i && x_cur[j]) g += 2 * longint'(w_mem[i][j]) * s;
      end
      gain[i] = 24'(g);
    end
    obj_cur = 29'(o);
    obj_best = obj_cur;
    x_best = x_cur;
  endtask

  task automatic predict_outcome(input step_t s);
    outcome_t r;
    int k;
    longint dk, si;
    logic signed [23:0] gk;
    r = '0;
    k = s.first_index;
    case (s.mode)
      qaem_pkg::MODE_WRITE: begin
        w_mem[s.first_index][s.second_index] = s.weight;
        w_mem[s.second_index][s.first_index] = s.weight;
      end
      qaem_pkg::MODE_START: x_cur[k] = s.bit_req;
      qaem_pkg::MODE_INIT: recompute_gains();
      qaem_pkg::MODE_PROPOSE: begin
        gk = gain[k];
        if (gk > 0) begin
          r.uphill = 1'b1;
          r.accepted = 1'b1;
        end else begin
          r.accepted = downhill_ok(gk, s.uniform, s.inv_temp);
        end
        if (r.accepted) begin
          x_cur[k] = ~x_cur[k];
          dk = x_cur[k] ? 1 : -1;
          obj_cur = 29'(longint'(obj_cur) + longint'(gk));
          for (int i = 0; i < NV; i++) begin
            si = x_cur[i] ? -1 : 1;
            if (i == k) gain[i] = 24'(-longint'(gain[i]));
            else gain[i] = 24'(longint'(gain[i]) + 2 * longint'(w_mem[i][k]) * si * dk);
          end
          if (obj_cur > obj_best) begin
            obj_best = obj_cur;
            x_best = x_cur;
          end
        end
      end
      qaem_pkg::MODE_READ: r.best_bit = x_best[k];
      default: ;
    endcase
    r.current_value = obj_cur;
    r.best_value = obj_best;
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
  endtask

  // drive one item, sometimes after a random gap; valid stays up until the next gap
  task automatic send_item(input step_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= s.mode;
    in_ch.first_index <= s.first_index;
    in_ch.second_index <= s.second_index;
    in_ch.weight <= s.weight;
    in_ch.bit_req <= s.bit_req;
    in_ch.uniform <= s.uniform;
    in_ch.inv_temp <= s.inv_temp;
    do @(posedge clk); while (!in_ch.ready);
    predict_outcome(s);
    @(negedge clk);
  endtask

  function automatic step_t rand_step(input logic [2:0] m);
    step_t s;
    s.mode = m;
    s.first_index = 6'($urandom);
    s.second_index = 6'($urandom);
    s.weight = 16'($urandom);
    if ($urandom_range(0, 3) != 0) s.weight = 16'($signed($urandom_range(0, 400)) - 200);
    s.bit_req = 1'($urandom);
    s.uniform = 16'($urandom);
    s.inv_temp = $urandom_range(0, 1) ? 16'($urandom_range(0, 2048)) : 16'($urandom);
    return s;
  endfunction

  // result side: random stalls, compare each result with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        outcome_t e;
        e = expected_q.pop_front();
        if (out_ch.accepted !== e.accepted) report_mismatch("accepted", out_ch.accepted, e.accepted);
        if (out_ch.uphill !== e.uphill) report_mismatch("uphill", out_ch.uphill, e.uphill);
        if (out_ch.current_value !== e.current_value)
          report_mismatch("current_value", out_ch.current_value, e.current_value);
        if (out_ch.best_value !== e.best_value)
          report_mismatch("best_value", out_ch.best_value, e.best_value);
        if (out_ch.best_bit !== e.best_bit) report_mismatch("best_bit", out_ch.best_bit, e.best_bit);
      end
    end
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    step_t s;
    // extreme and small weights on and off the diagonal, a start vector, an init
    s = rand_step(qaem_pkg::MODE_WRITE);
    s.first_index = 0; s.second_index = 0; s.weight = 16'sh7fff;
    send_item(s);
    s.first_index = 63; s.second_index = 0; s.weight = 16'sh8000; send_item(s);
    s.first_index = 63; s.second_index = 63; s.weight = 16'sh7fff; send_item(s);
    s.first_index = 5; s.second_index = 9; s.weight = -16'sd3; send_item(s);
    s = rand_step(qaem_pkg::MODE_START); s.first_index = 63; s.bit_req = 1; send_item(s);
    s.first_index = 0; s.bit_req = 1; send_item(s);
    s.first_index = 5; s.bit_req = 0; send_item(s);
    send_item(rand_step(qaem_pkg::MODE_INIT));
    // uphill, downhill with extreme uniform and temperature, then best-bit reads
    s = rand_step(qaem_pkg::MODE_PROPOSE);
    s.first_index = 9; s.uniform = 0; s.inv_temp = 0; send_item(s);
    s.first_index = 63; s.uniform = 16'hffff; s.inv_temp = 16'hffff; send_item(s);
    s.first_index = 0; s.uniform = 0; s.inv_temp = 1; send_item(s);
    s.first_index = 5; s.uniform = 16'hffff; s.inv_temp = 16'hffff; send_item(s);
    s = rand_step(qaem_pkg::MODE_READ); s.first_index = 0; send_item(s);
    s.first_index = 63; send_item(s);
    // unused mode codes change nothing
    s = rand_step(3'd5); send_item(s);
    s.mode = 3'd6; send_item(s);
    s.mode = 3'd7; send_item(s);
    // stale gains: change weights and bits after initialisation, then propose
    s = rand_step(qaem_pkg::MODE_WRITE);
    s.first_index = 9; s.second_index = 63; s.weight = 16'sd1000;
    send_item(s);
    s = rand_step(qaem_pkg::MODE_START); s.first_index = 9; s.bit_req = 1; send_item(s);
    s = rand_step(qaem_pkg::MODE_PROPOSE); s.first_index = 9; send_item(s);
  endtask

  task automatic test_anneal_random(input int n);
    step_t s;
    int r;
    for (int i = 0; i < n; i++) begin
      if (i > n - n / 6) idle_on = 1'b0;
      r = $urandom_range(0, 99);
      // mostly proposals on a set-up problem, with rebuilds and noise
      if (r < 12) s = rand_step(qaem_pkg::MODE_WRITE);
      else if (r < 20) s = rand_step(qaem_pkg::MODE_START);
      else if (r < 24) s = rand_step(qaem_pkg::MODE_INIT);
      else if (r < 88) s = rand_step(qaem_pkg::MODE_PROPOSE);
      else if (r < 97) s = rand_step(qaem_pkg::MODE_READ);
      else s = rand_step(3'($urandom_range(5, 7)));
      send_item(s);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = qaem_pkg::MODE_WRITE;
    in_ch.first_index = '0;
    in_ch.second_index = '0;
    in_ch.weight = '0;
    in_ch.bit_req = 1'b0;
    in_ch.uniform = '0;
    in_ch.inv_temp = '0;
    out_ch.ready = 1'b0;
    foreach (w_mem[i, j]) w_mem[i][j] = '0;
    foreach (gain[i]) gain[i] = '0;
    x_cur = '0;
    x_best = '0;
    obj_cur = '0;
    obj_best = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_anneal_random(1400);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
